/* hdl/prle_pkg.sv */
package prle_pkg;

    // Default payload limit, including the slot that the overflowing byte would take
    localparam int MAX_PAYLOAD_DEF = 150;

    // Reset value of the station address character ('a')
    localparam logic [6:0] STATION_RESET = 7'h61;

    // Link control characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_AT  = 8'h40;

    // Characters used to classify a message
    localparam logic [7:0] ASC_A = 8'h41;
    localparam logic [7:0] ASC_C = 8'h43;
    localparam logic [7:0] ASC_D = 8'h44;
    localparam logic [7:0] ASC_E = 8'h45;
    localparam logic [7:0] ASC_K = 8'h4B;
    localparam logic [7:0] ASC_N = 8'h4E;
    localparam logic [7:0] ASC_O = 8'h4F;
    localparam logic [7:0] ASC_P = 8'h50;
    localparam logic [7:0] ASC_S = 8'h53;
    localparam logic [7:0] ASC_T = 8'h54;
    localparam logic [7:0] ASC_W = 8'h57;

    // Configuration register word index
    localparam logic REG_STATION = 1'b0;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_BYTE    = 2'd1,
        CMD_TIMEOUT = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_FINISH  = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        ST_EOS       = 5'd0,
        ST_CARD      = 5'd1,
        ST_CARD_REV  = 5'd2,
        ST_CARD_OUT  = 5'd3,
        ST_PWR_ON    = 5'd4,
        ST_PWR_NG    = 5'd5,
        ST_PRN_ABN   = 5'd6,
        ST_PAPER     = 5'd7,
        ST_NO_PAPER  = 5'd8,
        ST_PRN_ACK   = 5'd9,
        ST_K         = 5'd10,
        ST_N         = 5'd11,
        ST_OTHER     = 5'd12,
        ST_NAK       = 5'd13,
        ST_BAD_START = 5'd14,
        ST_OVERFLOW  = 5'd15,
        ST_NO_EOT    = 5'd16,
        ST_TIMEOUT   = 5'd17
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_OPEN   = 3'd1,
        PH_TEXT   = 3'd2,
        PH_BCC    = 3'd3,
        PH_CLOSE1 = 3'd4,
        PH_CLOSE2 = 3'd5
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        status_t    status;
    } res_t;

    // Up to three results caused by one request; entry 0 goes out first
    typedef struct packed {
        res_t [2:0] r;
        logic [1:0] n;
    } burst_t;

    function automatic res_t mk_res(kind_t kind, logic [7:0] data, status_t status);
        res_t res;
        res.kind   = kind;
        res.data   = data;
        res.status = status;
        return res;
    endfunction

endpackage

/* hdl/prle_ctrl.sv */
module prle_ctrl
    import prle_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [1:0] command,
    input  logic [7:0] rx_byte,
    input  logic [6:0] station_char,
    output burst_t     burst
);

    localparam logic [7:0] COUNT_LIMIT = 8'(MAX_PAYLOAD - 1);

    phase_t     phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] third_reg, third_next;
    cmd_t       cmd;

    assign cmd = cmd_t'(command);

    // Classify the message from its first and third characters
    function automatic status_t classify(logic [7:0] a, logic [7:0] c);
        status_t st;
        st = ST_OTHER;
        if (a == ASC_C && c == ASC_D)      st = ST_CARD;
        else if (a == ASC_C && c == ASC_W) st = ST_CARD_REV;
        else if (a == ASC_C && c == ASC_O) st = ST_CARD_OUT;
        else if (a == ASC_S && c == ASC_O) st = ST_PWR_ON;
        else if (a == ASC_S && c == ASC_N) st = ST_PWR_NG;
        else if (a == ASC_P && c == ASC_T) st = ST_PRN_ABN;
        else if (a == ASC_P && c == ASC_N) st = ST_PAPER;
        else if (a == ASC_P && c == ASC_E) st = ST_NO_PAPER;
        else if (a == ASC_P && c == ASC_A) st = ST_PRN_ACK;
        else if (a == ASC_K)               st = ST_K;
        else if (a == ASC_N)               st = ST_N;
        return st;
    endfunction

    // Next state of the session
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        first_next = first_reg;
        third_next = third_reg;
        case (cmd)
            CMD_START:
            begin
                phase_next = PH_OPEN;
                count_next = '0;
                first_next = '0;
                third_next = '0;
            end
            CMD_TIMEOUT:
            begin
                if (phase_reg == PH_TEXT)
                begin
                    phase_next = PH_IDLE;
                end
            end
            CMD_BYTE:
            begin
                case (phase_reg)
                    PH_OPEN:
                    begin
                        if (rx_byte == CH_STX)
                        begin
                            phase_next = PH_TEXT;
                            count_next = '0;
                            first_next = '0;
                            third_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_TEXT:
                    begin
                        if (rx_byte == CH_ETX)
                        begin
                            phase_next = PH_BCC;
                        end
                        else if (count_reg >= COUNT_LIMIT)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            if (count_reg == 8'd0)
                            begin
                                first_next = rx_byte;
                            end
                            if (count_reg == 8'd2)
                            begin
                                third_next = rx_byte;
                            end
                            count_next = count_reg + 8'd1;
                        end
                    end
                    PH_BCC:
                    begin
                        phase_next = PH_CLOSE1;
                    end
                    PH_CLOSE1:
                    begin
                        phase_next = (rx_byte == CH_EOT) ? PH_IDLE : PH_CLOSE2;
                    end
                    PH_CLOSE2:
                    begin
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Results caused by the request
    always_comb
    begin
        burst.r[0] = mk_res(KIND_TX, 8'h00, ST_EOS);
        burst.r[1] = mk_res(KIND_TX, 8'h00, ST_EOS);
        burst.r[2] = mk_res(KIND_TX, 8'h00, ST_EOS);
        burst.n    = 2'd0;
        case (cmd)
            CMD_START:
            begin
                burst.r[0] = mk_res(KIND_TX, CH_AT, ST_EOS);
                burst.r[1] = mk_res(KIND_TX, {1'b0, station_char}, ST_EOS);
                burst.r[2] = mk_res(KIND_TX, CH_ENQ, ST_EOS);
                burst.n    = 2'd3;
            end
            CMD_TIMEOUT:
            begin
                if (phase_reg == PH_TEXT)
                begin
                    burst.r[0] = mk_res(KIND_FINISH, 8'h00, ST_TIMEOUT);
                    burst.n    = 2'd1;
                end
            end
            CMD_BYTE:
            begin
                case (phase_reg)
                    PH_OPEN:
                    begin
                        if (rx_byte == CH_EOT)
                        begin
                            burst.r[0] = mk_res(KIND_TX, CH_EOT, ST_EOS);
                            burst.r[1] = mk_res(KIND_FINISH, 8'h00, ST_EOS);
                            burst.n    = 2'd2;
                        end
                        else if (rx_byte == CH_NAK)
                        begin
                            burst.r[0] = mk_res(KIND_TX, CH_EOT, ST_EOS);
                            burst.r[1] = mk_res(KIND_FINISH, 8'h00, ST_NAK);
                            burst.n    = 2'd2;
                        end
                        else if (rx_byte != CH_STX)
                        begin
                            burst.r[0] = mk_res(KIND_FINISH, 8'h00, ST_BAD_START);
                            burst.n    = 2'd1;
                        end
                    end
                    PH_TEXT:
                    begin
                        if (rx_byte != CH_ETX)
                        begin
                            if (count_reg >= COUNT_LIMIT)
                            begin
                                burst.r[0] = mk_res(KIND_FINISH, 8'h00, ST_OVERFLOW);
                            end
                            else
                            begin
                                burst.r[0] = mk_res(KIND_PAYLOAD, rx_byte, ST_EOS);
                            end
                            burst.n = 2'd1;
                        end
                    end
                    PH_BCC:
                    begin
                        burst.r[0] = mk_res(KIND_TX, CH_ACK, ST_EOS);
                        burst.n    = 2'd1;
                    end
                    PH_CLOSE1:
                    begin
                        if (rx_byte == CH_EOT)
                        begin
                            burst.r[0] = mk_res(KIND_FINISH, 8'h00,
                                                classify(first_reg, third_reg));
                        end
                        else
                        begin
                            burst.r[0] = mk_res(KIND_TX, CH_ACK, ST_EOS);
                        end
                        burst.n = 2'd1;
                    end
                    PH_CLOSE2:
                    begin
                        if (rx_byte == CH_EOT)
                        begin
                            burst.r[0] = mk_res(KIND_FINISH, 8'h00,
                                                classify(first_reg, third_reg));
                        end
                        else
                        begin
                            burst.r[0] = mk_res(KIND_FINISH, 8'h00, ST_NO_EOT);
                        end
                        burst.n = 2'd1;
                    end
                    default:
                    begin
                        burst.n = 2'd0;
                    end
                endcase
            end
            default:
            begin
                burst.n = 2'd0;
            end
        endcase
    end

    // Advance the session on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            first_reg <= '0;
            third_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            first_reg <= first_next;
            third_reg <= third_next;
        end
    end

`ifndef SYNTH
    a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_START) |=> (phase_reg == PH_OPEN && count_reg == 8'd0))
        else $error("start request did not open a session");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_TEXT && cmd == CMD_BYTE && burst.r[0].kind == KIND_PAYLOAD)
        |=> (count_reg <= COUNT_LIMIT))
        else $error("payload count passed the limit");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE && cmd != CMD_START) |-> (burst.n == 2'd0))
        else $error("idle session produced results");
`endif

endmodule

/* hdl/poll_receive_link_engine.sv */
// A request's results are registered in the output stage, else parked in the skid stage.
// Throughput: one request per cycle while each causes at most one result and m_tready
// is high; a request causing n results sends one per cycle while m_tready is high.
// A two-deep burst buffer (output plus one skid) lets a request in while results wait.
// Reset: asynchronous, active low; session idle, buffers empty, station 'a'.
module poll_receive_link_engine
    import prle_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [1:0]  s_tuser,    // [1:0] command

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] data_byte, [12:8] status, [15:13] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       [6:0] station_reg;
    res_t       [2:0] front_res_reg, front_res_next;
    logic       [1:0] front_cnt_reg, front_cnt_next;
    burst_t           back_reg, back_next;
    logic             back_valid_reg, back_valid_next;
    burst_t           step_burst;
    logic             in_accept;
    logic             take;
    logic             front_drains;
    logic             new_has;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STATION) ? {25'd0, station_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= STATION_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_STATION)
        begin
            station_reg <= pwdata[6:0];
        end
    end

    // Session control and result generation
    prle_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .command      (s_tuser),
        .rx_byte      (s_tdata),
        .station_char (station_reg),
        .burst        (step_burst)
    );

    assign s_tready     = !back_valid_reg;
    assign in_accept    = s_tvalid && s_tready;
    assign new_has      = in_accept && (step_burst.n != 2'd0);
    assign take         = m_tvalid && m_tready;
    assign front_drains = (front_cnt_reg == 2'd0) || (take && front_cnt_reg == 2'd1);

    // Output side
    assign m_tvalid = (front_cnt_reg != 2'd0);
    assign m_tuser  = front_res_reg[0].kind;
    assign m_tdata  = {3'd0, front_res_reg[0].status, front_res_reg[0].data};
    assign m_tlast  = (front_cnt_reg == 2'd1);

    // Refill the front from the skid stage or new request, else shift and park new in skid
    always_comb
    begin
        front_res_next  = front_res_reg;
        front_cnt_next  = front_cnt_reg;
        back_next       = back_reg;
        back_valid_next = back_valid_reg;
        if (back_valid_reg && front_drains)
        begin
            front_res_next  = back_reg.r;
            front_cnt_next  = back_reg.n;
            back_valid_next = 1'b0;
        end
        else if (new_has && front_drains)
        begin
            front_res_next = step_burst.r;
            front_cnt_next = step_burst.n;
        end
        else
        begin
            if (take)
            begin
                front_res_next[0] = front_res_reg[1];
                front_res_next[1] = front_res_reg[2];
                front_cnt_next    = front_cnt_reg - 2'd1;
            end
            if (new_has)
            begin
                back_next       = step_burst;
                back_valid_next = 1'b1;
            end
        end
    end

    // Hold the buffer control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cnt_reg  <= 2'd0;
            back_valid_reg <= 1'b0;
        end
        else
        begin
            front_cnt_reg  <= front_cnt_next;
            back_valid_reg <= back_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        front_res_reg <= front_res_next;
        back_reg      <= back_next;
    end

`ifndef SYNTH
    a_back_needs_front: assert property (@(posedge clk) disable iff (!rst_n)
        back_valid_reg |-> (front_cnt_reg != 2'd0))
        else $error("skid stage full while output stage empty");

    a_back_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (back_valid_reg && take && front_cnt_reg == 2'd1) |=> !back_valid_reg)
        else $error("skid stage not moved on when output stage drained");

    a_burst_single: assert property (@(posedge clk) disable iff (!rst_n)
        (new_has && front_drains && !back_valid_reg)
        |=> (m_tvalid && front_cnt_reg == $past(step_burst.n)))
        else $error("new results not loaded into empty output stage");
`endif

endmodule
